[src/cda_pkg.sv]
// Shared types, constants and calendar helpers for the calendar date adder.
// Used by cda_divider and calendar_date_adder_unit; depends on nothing.
package cda_pkg;

	localparam int YEAR_BITS   = 16;
	localparam int AMOUNT_BITS = 12;

	// month - 1 + amount needs one bit above the amount
	localparam int TOTAL_BITS = AMOUNT_BITS + 1;
	// day + amount, day up to 31
	localparam int DAYS_BITS  = ((AMOUNT_BITS > 5) ? AMOUNT_BITS : 5) + 1;
	// year + added years, one carry bit for the overflow check
	localparam int SUM_BITS   = ((YEAR_BITS > AMOUNT_BITS) ? YEAR_BITS : AMOUNT_BITS) + 1;
	// divider dividend: holds a year or a month total
	localparam int DIV_BITS   = (YEAR_BITS > TOTAL_BITS) ? YEAR_BITS : TOTAL_BITS;

	// year / 400 = (year >> 4) / 25; reciprocal of 25 is exact below 2^30
	localparam int          RCP_CYC_SHIFT = 32;
	localparam logic [27:0] RCP_CYC       = 28'd171798692;
	localparam int          CYC_X_BITS    = DIV_BITS - 4;
	localparam int          CYC_P_BITS    = CYC_X_BITS + 28;
	// total / 12 = (total >> 2) / 3; reciprocal of 3 is exact below 2^19
	localparam int          RCP_MON_SHIFT = 20;
	localparam logic [18:0] RCP_MON       = 19'd349526;
	localparam int          MON_X_BITS    = TOTAL_BITS - 2;
	localparam int          MON_P_BITS    = MON_X_BITS + 19;

	localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;

	localparam logic [8:0] DIV_MONTHS = 9'd12;
	localparam logic [8:0] DIV_CYCLE  = 9'd400;
	localparam logic [8:0] CYCLE_LAST = 9'd399;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_DAYS   = 2'd1;
	localparam logic [1:0] REQ_MONTHS = 2'd2;
	localparam logic [1:0] REQ_YEARS  = 2'd3;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_BAD  = 2'd1;
	localparam logic [1:0] STATUS_SAT  = 2'd2;

	localparam logic [3:0] MON_FEB = 4'd2;
	localparam logic [3:0] MON_DEC = 4'd12;

	typedef struct packed {
		logic                go;
		logic [8:0]          divisor;
		logic [DIV_BITS-1:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [DIV_BITS-1:0] quo;
		logic [8:0]          rem;
	} div_rsp_t;

	// leap test from the year modulo 400
	function automatic logic is_leap400(input logic [8:0] r);
		is_leap400 = (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
	endfunction

	// days in a month; out-of-range months count as 31
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		case (m)
			4'd2:  month_len = leap ? 5'd29 : 5'd28;
			4'd4:  month_len = 5'd30;
			4'd6:  month_len = 5'd30;
			4'd9:  month_len = 5'd30;
			4'd11: month_len = 5'd30;
			default: month_len = 5'd31;
		endcase
	endfunction

endpackage

[src/cda_divider.sv]
// Divider by 12 or 400 through reciprocal multiplication, three registered stages.
// Depends on cda_pkg for widths, reciprocals and the request/response structs.
module cda_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  cda_pkg::div_req_t req,
	output cda_pkg::div_rsp_t rsp
);

	logic                           go_s1;
	logic                           go_s2;
	logic                           done_q;
	logic [cda_pkg::DIV_BITS-1:0]   dvd_s1;
	logic [8:0]                     div_s1;
	logic [cda_pkg::DIV_BITS-1:0]   dvd_s2;
	logic [8:0]                     div_s2;
	logic [cda_pkg::DIV_BITS-1:0]   quo_s2;
	logic [cda_pkg::DIV_BITS-1:0]   quo_q;
	logic [8:0]                     rem_q;
	logic [cda_pkg::CYC_P_BITS-1:0] prod_cyc;
	logic [cda_pkg::MON_P_BITS-1:0] prod_mon;
	logic [cda_pkg::DIV_BITS-1:0]   quo_cyc;
	logic [cda_pkg::DIV_BITS-1:0]   quo_mon;
	logic [cda_pkg::DIV_BITS-1:0]   back;
	logic [cda_pkg::DIV_BITS-1:0]   diff;

	// quotient from the pre-shifted dividend times the reciprocal
	assign prod_cyc = cda_pkg::CYC_P_BITS'(dvd_s1[cda_pkg::DIV_BITS-1:4])
	                  * cda_pkg::CYC_P_BITS'(cda_pkg::RCP_CYC);
	assign prod_mon = cda_pkg::MON_P_BITS'(dvd_s1[cda_pkg::TOTAL_BITS-1:2])
	                  * cda_pkg::MON_P_BITS'(cda_pkg::RCP_MON);
	assign quo_cyc  = cda_pkg::DIV_BITS'(prod_cyc[cda_pkg::CYC_P_BITS-1:cda_pkg::RCP_CYC_SHIFT]);
	assign quo_mon  = cda_pkg::DIV_BITS'(prod_mon[cda_pkg::MON_P_BITS-1:cda_pkg::RCP_MON_SHIFT]);

	// remainder by subtracting quotient times divisor
	assign back = quo_s2 * cda_pkg::DIV_BITS'(div_s2);
	assign diff = dvd_s2 - back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1  <= 1'b0;
			go_s2  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			go_s1  <= req.go;
			go_s2  <= go_s1;
			done_q <= go_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			dvd_s1 <= req.dividend;
			div_s1 <= req.divisor;
		end
		if (go_s1) begin
			dvd_s2 <= dvd_s1;
			div_s2 <= div_s1;
			quo_s2 <= (div_s1 == cda_pkg::DIV_CYCLE) ? quo_cyc : quo_mon;
		end
		if (go_s2) begin
			quo_q <= quo_s2;
			rem_q <= diff[8:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

[src/calendar_date_adder_unit.sv]
// Calendar date adder top level, held Gregorian date; built on cda_pkg and cda_divider.
// A load runs the year % 400 divide and then checks the day; a year add checks overflow,
// then runs the year % 400 divide; a month add first divides the month total by 12; a day
// add walks month by month. One item at a time, busy for the whole item, so a new request
// is taken only once the last result is out. Results cannot be stalled.
// Reset (async, active low) gives 1 January of year 1, idle, no result pending.
module calendar_date_adder_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      req_type,
	input  logic [4:0]                      load_day,
	input  logic [3:0]                      load_month,
	input  logic [cda_pkg::YEAR_BITS-1:0]   load_year,
	input  logic [cda_pkg::AMOUNT_BITS-1:0] amount,
	output logic                            done,
	output logic [4:0]                      cur_day,
	output logic [3:0]                      cur_month,
	output logic [cda_pkg::YEAR_BITS-1:0]   cur_year,
	output logic [1:0]                      status
);

	// sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_MON_GO   = 4'd1;  // launch total / 12
	localparam logic [3:0] S_MON_WAIT = 4'd2;
	localparam logic [3:0] S_YEAR_ADD = 4'd3;  // add years, overflow check
	localparam logic [3:0] S_MOD_GO   = 4'd4;  // launch year % 400
	localparam logic [3:0] S_MOD_WAIT = 4'd5;
	localparam logic [3:0] S_LOAD_DAY = 4'd6;  // check loaded day vs new month
	localparam logic [3:0] S_SETTLE   = 4'd7;  // clamp day after month/year add
	localparam logic [3:0] S_WALK     = 4'd8;  // add days, one month per cycle

	logic [3:0]                      state_q;
	logic                            done_q;
	logic [1:0]                      status_q;
	logic [1:0]                      req_q;
	logic [4:0]                      day_q;
	logic [3:0]                      month_q;
	logic [cda_pkg::YEAR_BITS-1:0]   year_q;
	logic [8:0]                      yr400_q;   // year modulo 400, tracks year_q
	logic [4:0]                      ld_day_q;
	logic                            was_last_q;
	logic [cda_pkg::AMOUNT_BITS-1:0] addy_q;
	logic [cda_pkg::TOTAL_BITS-1:0]  total_q;
	logic [cda_pkg::DAYS_BITS-1:0]   days_q;

	logic [4:0]                      len_cur;
	logic [cda_pkg::SUM_BITS-1:0]    year_sum;
	logic [cda_pkg::DAYS_BITS-1:0]   len_ext;

	cda_pkg::div_req_t div_req;
	cda_pkg::div_rsp_t div_rsp;

	cda_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// February length always follows the tracked year remainder
	assign len_cur  = cda_pkg::month_len(month_q, cda_pkg::is_leap400(yr400_q));
	assign len_ext  = cda_pkg::DAYS_BITS'(len_cur);
	assign year_sum = cda_pkg::SUM_BITS'(year_q) + cda_pkg::SUM_BITS'(addy_q);

	always_comb begin
		div_req.go       = (state_q == S_MON_GO) || (state_q == S_MOD_GO);
		div_req.divisor  = (state_q == S_MON_GO) ? cda_pkg::DIV_MONTHS : cda_pkg::DIV_CYCLE;
		div_req.dividend = (state_q == S_MON_GO) ? cda_pkg::DIV_BITS'(total_q)
		                                         : cda_pkg::DIV_BITS'(year_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			status_q <= cda_pkg::STATUS_OK;
			day_q    <= 5'd1;
			month_q  <= 4'd1;
			year_q   <= cda_pkg::YEAR_BITS'(1);
			yr400_q  <= 9'd1;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q <= cda_pkg::STATUS_OK;
						case (req_type)
							cda_pkg::REQ_LOAD: begin
								if (load_month >= 4'd1 && load_month <= cda_pkg::MON_DEC)
									month_q <= load_month;
								else
									status_q <= cda_pkg::STATUS_BAD;
								if (load_year != '0)
									year_q <= load_year;
								else
									status_q <= cda_pkg::STATUS_BAD;
								state_q <= S_MOD_GO;
							end
							cda_pkg::REQ_DAYS: begin
								state_q <= S_WALK;
							end
							cda_pkg::REQ_MONTHS: begin
								state_q <= S_MON_GO;
							end
							default: begin
								state_q <= S_YEAR_ADD;
							end
						endcase
					end
				end
				S_MON_GO: state_q <= S_MON_WAIT;
				S_MON_WAIT: begin
					if (div_rsp.done) begin
						month_q <= 4'(div_rsp.rem + 9'd1);
						state_q <= S_YEAR_ADD;
					end
				end
				S_YEAR_ADD: begin
					if (year_sum > cda_pkg::SUM_BITS'(cda_pkg::YEAR_MAX)) begin
						day_q    <= 5'd31;
						month_q  <= cda_pkg::MON_DEC;
						year_q   <= cda_pkg::YEAR_MAX;
						status_q <= cda_pkg::STATUS_SAT;
					end else begin
						year_q <= year_sum[cda_pkg::YEAR_BITS-1:0];
					end
					state_q <= S_MOD_GO;
				end
				S_MOD_GO: state_q <= S_MOD_WAIT;
				S_MOD_WAIT: begin
					if (div_rsp.done) begin
						yr400_q <= div_rsp.rem;
						if (req_q == cda_pkg::REQ_LOAD)
							state_q <= S_LOAD_DAY;
						else if (status_q == cda_pkg::STATUS_SAT) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end else
							state_q <= S_SETTLE;
					end
				end
				S_LOAD_DAY: begin
					if (ld_day_q >= 5'd1 && ld_day_q <= len_cur)
						day_q <= ld_day_q;
					else begin
						status_q <= cda_pkg::STATUS_BAD;
						// kept day may not fit the new month
						if (day_q > len_cur)
							day_q <= len_cur;
						else if (day_q == 5'd0)
							day_q <= 5'd1;
					end
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				S_SETTLE: begin
					// last day stays last day, others clamp
					if (was_last_q || day_q > len_cur)
						day_q <= len_cur;
					else if (day_q == 5'd0)
						day_q <= 5'd1;
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				S_WALK: begin
					if (days_q <= len_ext) begin
						day_q   <= days_q[4:0];
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else if (month_q >= cda_pkg::MON_DEC) begin
						if (year_q == cda_pkg::YEAR_MAX) begin
							day_q    <= 5'd31;
							month_q  <= cda_pkg::MON_DEC;
							status_q <= cda_pkg::STATUS_SAT;
							state_q  <= S_MOD_GO;
						end else begin
							year_q  <= year_q + 1'b1;
							month_q <= 4'd1;
							yr400_q <= (yr400_q == cda_pkg::CYCLE_LAST) ? 9'd0 : yr400_q + 9'd1;
						end
					end else begin
						month_q <= month_q + 4'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request payload, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q      <= req_type;
			ld_day_q   <= load_day;
			was_last_q <= (day_q == len_cur);
			addy_q     <= amount;
			total_q    <= cda_pkg::TOTAL_BITS'(month_q) - cda_pkg::TOTAL_BITS'(1)
			              + cda_pkg::TOTAL_BITS'(amount);
			days_q     <= cda_pkg::DAYS_BITS'(day_q) + cda_pkg::DAYS_BITS'(amount);
		end else if (state_q == S_MON_WAIT && div_rsp.done) begin
			addy_q <= div_rsp.quo[cda_pkg::AMOUNT_BITS-1:0];
		end else if (state_q == S_WALK && days_q > len_ext) begin
			days_q <= days_q - len_ext;
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign cur_day   = day_q;
	assign cur_month = month_q;
	assign cur_year  = year_q;
	assign status    = status_q;

`ifndef ASSERT_OFF
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in flight");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not start the sequencer");

	a_yr400_range: assert property (@(posedge clk) disable iff (!arst_n)
		yr400_q < cda_pkg::DIV_CYCLE)
		else $error("year remainder out of range");

	a_month_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (cur_month >= 4'd1 && cur_month <= cda_pkg::MON_DEC))
		else $error("result month out of range");

	a_day_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (cur_day >= 5'd1 && cur_day <= len_cur))
		else $error("result day outside its month");
`endif

endmodule

[sim/testbench.sv]
// Self-checking bench for calendar_date_adder_unit: directed calendar corners, then random
// load/add streams checked against an in-bench date predictor.
// Depends on cda_pkg and the RTL under src/.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_ITEMS = 800;
	localparam int unsigned DRAIN_CYCLES = 200;
	localparam int unsigned CYCLE_LIMIT  = 1000000;

	typedef struct {
		logic [1:0]                      req;
		logic [4:0]                      day;
		logic [3:0]                      mon;
		logic [cda_pkg::YEAR_BITS-1:0]   year;
		logic [cda_pkg::AMOUNT_BITS-1:0] amt;
		int unsigned                     gap;	// idle cycles before this item is offered
	} date_cmd_t;

	typedef struct {
		logic [4:0]                    day;
		logic [3:0]                    mon;
		logic [cda_pkg::YEAR_BITS-1:0] year;
		logic [1:0]                    status;
	} date_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            start = 1'b0;
	logic [1:0]                      req_type = cda_pkg::REQ_LOAD;
	logic [4:0]                      load_day = '0;
	logic [3:0]                      load_month = '0;
	logic [cda_pkg::YEAR_BITS-1:0]   load_year = '0;
	logic [cda_pkg::AMOUNT_BITS-1:0] amount = '0;
	logic                            busy;
	logic                            done;
	logic [4:0]                      cur_day;
	logic [3:0]                      cur_month;
	logic [cda_pkg::YEAR_BITS-1:0]   cur_year;
	logic [1:0]                      status;

	calendar_date_adder_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.load_day   (load_day),
		.load_month (load_month),
		.load_year  (load_year),
		.amount     (amount),
		.done       (done),
		.cur_day    (cur_day),
		.cur_month  (cur_month),
		.cur_year   (cur_year),
		.status     (status)
	);

	// predicted held date
	logic [4:0]                    held_day  = 5'd1;
	logic [3:0]                    held_mon  = 4'd1;
	logic [cda_pkg::YEAR_BITS-1:0] held_year = cda_pkg::YEAR_BITS'(1);

	date_cmd_t   requests[$];
	date_t       due_dates[$];
	int unsigned gap_left = 0;
	int unsigned total_cmds = 0;
	int unsigned accepted = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned saturations = 0;
	int unsigned bad_loads = 0;
	int unsigned kind_count[4] = '{0, 0, 0, 0};
	int unsigned cycle_count = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic bit leap_year(input longint unsigned y);
		return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
	endfunction

	function automatic longint unsigned days_in_month(input longint unsigned m,
			input longint unsigned y);
		if (m < 1 || m > 12)
			return 31;
		if (m == cda_pkg::MON_FEB)
			return leap_year(y) ? 29 : 28;
		case (m)
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	function automatic void saturate_held();
		held_day  = 5'd31;
		held_mon  = cda_pkg::MON_DEC;
		held_year = cda_pkg::YEAR_MAX;
	endfunction

	// clamp the day into the held month; a last-day date follows the month end
	function automatic void fit_day(input bit was_last);
		longint unsigned len;
		len = days_in_month(held_mon, held_year);
		if (was_last || held_day > len)
			held_day = len[4:0];
		if (held_day < 1)
			held_day = 5'd1;
	endfunction

	// apply one request to the held date and return the result it produces
	function automatic date_t advance_date(input date_cmd_t c);
		longint unsigned d, total, add_y;
		bit was_last;
		date_t r;
		r.status = cda_pkg::STATUS_OK;
		case (c.req)
			cda_pkg::REQ_LOAD: begin
				// month and year first, the day is judged against the new month
				if (c.mon >= 1 && c.mon <= 12)
					held_mon = c.mon;
				else
					r.status = cda_pkg::STATUS_BAD;
				if (c.year != 0)
					held_year = c.year;
				else
					r.status = cda_pkg::STATUS_BAD;
				if (c.day >= 1 && c.day <= days_in_month(held_mon, held_year))
					held_day = c.day;
				else
					r.status = cda_pkg::STATUS_BAD;
				fit_day(1'b0);
			end
			cda_pkg::REQ_DAYS: begin
				d = held_day + c.amt;
				while (r.status == cda_pkg::STATUS_OK
						&& d > days_in_month(held_mon, held_year)) begin
					d -= days_in_month(held_mon, held_year);
					if (held_mon >= cda_pkg::MON_DEC) begin
						if (held_year == cda_pkg::YEAR_MAX) begin
							saturate_held();
							r.status = cda_pkg::STATUS_SAT;
						end else begin
							held_year = held_year + 1'b1;
							held_mon  = 4'd1;
						end
					end else begin
						held_mon = held_mon + 1'b1;
					end
				end
				if (r.status == cda_pkg::STATUS_OK)
					held_day = d[4:0];
			end
			default: begin
				was_last = (held_day == days_in_month(held_mon, held_year));
				if (c.req == cda_pkg::REQ_MONTHS) begin
					total    = (held_mon - 1) + c.amt;
					add_y    = total / 12;
					held_mon = 4'(total % 12 + 1);
				end else begin
					add_y = c.amt;
				end
				if (held_year + add_y > cda_pkg::YEAR_MAX) begin
					saturate_held();
					r.status = cda_pkg::STATUS_SAT;
				end else begin
					held_year = cda_pkg::YEAR_BITS'(held_year + add_y);
					fit_day(was_last);
				end
			end
		endcase
		r.day  = held_day;
		r.mon  = held_mon;
		r.year = held_year;
		return r;
	endfunction

	task automatic add_cmd(input logic [1:0] req, input int unsigned dy, input int unsigned mo,
			input int unsigned yr, input int unsigned amt, input int unsigned gap);
		date_cmd_t c;
		c.req  = req;
		c.day  = dy[4:0];
		c.mon  = mo[3:0];
		c.year = yr[cda_pkg::YEAR_BITS-1:0];
		c.amt  = amt[cda_pkg::AMOUNT_BITS-1:0];
		c.gap  = gap;
		requests.push_back(c);
		total_cmds++;
	endtask

	task automatic offer_next();
		date_cmd_t c;
		c = requests.pop_front();
		start      <= 1'b1;
		req_type   <= c.req;
		load_day   <= c.day;
		load_month <= c.mon;
		load_year  <= c.year;
		amount     <= c.amt;
	endtask

	// Driver: an item is taken at an edge with start high and busy low. The idle
	// count runs from acceptance, so the next start can rise while the block works.
	always @(posedge clk) begin : driver
		date_cmd_t c;
		date_t r;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !busy) begin
			c.req  = req_type;
			c.day  = load_day;
			c.mon  = load_month;
			c.year = load_year;
			c.amt  = amount;
			c.gap  = 0;
			r = advance_date(c);
			due_dates.push_back(r);
			accepted++;
			kind_count[c.req]++;
			if (r.status == cda_pkg::STATUS_SAT)
				saturations++;
			if (r.status == cda_pkg::STATUS_BAD)
				bad_loads++;
			if (requests.size() != 0 && requests[0].gap == 0) begin
				offer_next();
			end else begin
				start    <= 1'b0;
				gap_left <= (requests.size() != 0) ? requests[0].gap - 1 : 0;
			end
		end else if (!start) begin
			if (gap_left != 0)
				gap_left <= gap_left - 1;
			else if (requests.size() != 0)
				offer_next();
		end
	end

	// Monitor: done marks one result cycle; it cannot be held off.
	always @(posedge clk) begin : monitor
		date_t want;
		if (arst_n && done) begin
			results_seen++;
			if (due_dates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d/%0d/%0d status %0d, nothing outstanding",
						cur_day, cur_month, cur_year, status);
			end else begin
				want = due_dates.pop_front();
				if (cur_day !== want.day || cur_month !== want.mon ||
						cur_year !== want.year || status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: got %0d/%0d/%0d status %0d, want %0d/%0d/%0d status %0d",
							results_seen, cur_day, cur_month, cur_year, status,
							want.day, want.mon, want.year, want.status);
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d of %0d items accepted", cycle_count,
			accepted, total_cmds);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		int unsigned yr, mo, dy, amt, gap, pick;
		bit calm;
		logic [1:0] kind;

		// zero amounts from the reset date
		add_cmd(cda_pkg::REQ_DAYS, 0, 0, 0, 0, 0);
		add_cmd(cda_pkg::REQ_MONTHS, 0, 0, 0, 0, 3);
		add_cmd(cda_pkg::REQ_YEARS, 0, 0, 0, 0, 0);
		// leap rule: divisible by 400, by 100 only, by 4
		add_cmd(cda_pkg::REQ_LOAD, 29, 2, 2000, 0, 0);
		add_cmd(cda_pkg::REQ_LOAD, 29, 2, 1900, 0, 7);
		add_cmd(cda_pkg::REQ_LOAD, 29, 2, 2024, 0, 0);
		// last day of February follows the month end across years
		add_cmd(cda_pkg::REQ_YEARS, 0, 0, 0, 1, 0);
		add_cmd(cda_pkg::REQ_YEARS, 0, 0, 0, 3, 15);
		// month add clamps, then last day sticks
		add_cmd(cda_pkg::REQ_LOAD, 31, 1, 2023, 0, 0);
		add_cmd(cda_pkg::REQ_MONTHS, 0, 0, 0, 1, 0);
		add_cmd(cda_pkg::REQ_MONTHS, 0, 0, 0, 1, 0);
		// day bound inclusive; bad day, month and year fields keep old values
		add_cmd(cda_pkg::REQ_LOAD, 30, 4, 2023, 0, 0);
		add_cmd(cda_pkg::REQ_LOAD, 31, 4, 2023, 0, 0);
		add_cmd(cda_pkg::REQ_LOAD, 0, 6, 2023, 0, 0);
		add_cmd(cda_pkg::REQ_LOAD, 15, 0, 2023, 0, 0);
		add_cmd(cda_pkg::REQ_LOAD, 15, 13, 2023, 0, 0);
		add_cmd(cda_pkg::REQ_LOAD, 31, 15, 65535, 0, 0);
		add_cmd(cda_pkg::REQ_LOAD, 10, 3, 0, 0, 0);
		// year saturation from each add type
		add_cmd(cda_pkg::REQ_LOAD, 31, 12, 65535, 0, 0);
		add_cmd(cda_pkg::REQ_DAYS, 0, 0, 0, 1, 0);
		add_cmd(cda_pkg::REQ_LOAD, 1, 1, 65535, 0, 0);
		add_cmd(cda_pkg::REQ_MONTHS, 0, 0, 0, 12, 0);
		add_cmd(cda_pkg::REQ_LOAD, 1, 1, 65535, 0, 0);
		add_cmd(cda_pkg::REQ_YEARS, 0, 0, 0, 1, 0);
		// largest amounts
		add_cmd(cda_pkg::REQ_LOAD, 1, 1, 1, 0, 0);
		add_cmd(cda_pkg::REQ_DAYS, 0, 0, 0, 4095, 0);
		add_cmd(cda_pkg::REQ_MONTHS, 0, 0, 0, 4095, 0);
		add_cmd(cda_pkg::REQ_YEARS, 0, 0, 0, 4095, 0);

		// random part: mostly valid loads followed by adds, some raw load fields
		calm = 1'b0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			gap  = calm ? 0 : $urandom_range(0, 15);
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: yr = $urandom_range(1, 65535);
					4, 5:       yr = $urandom_range(65500, 65535);
					6, 7:       yr = 100 * $urandom_range(1, 655);
					8:          yr = $urandom_range(1, 3000);
					default:    yr = 4 * $urandom_range(1, 16383);
				endcase
				mo = $urandom_range(1, 12);
				dy = ($urandom_range(0, 3) == 0) ? 32'(days_in_month(mo, yr))
					: $urandom_range(1, 32'(days_in_month(mo, yr)));
				add_cmd(cda_pkg::REQ_LOAD, dy, mo, yr, $urandom_range(0, 4095), gap);
			end else if (pick < 22) begin
				add_cmd(cda_pkg::REQ_LOAD, $urandom_range(0, 31), $urandom_range(0, 15),
					$urandom_range(0, 65535), $urandom_range(0, 4095), gap);
			end else begin
				kind = 2'($urandom_range(cda_pkg::REQ_DAYS, cda_pkg::REQ_YEARS));
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: amt = $urandom_range(0, 40);
					5, 6:          amt = $urandom_range(0, 400);
					7, 8:          amt = $urandom_range(0, 4095);
					default:       amt = ($urandom_range(0, 2) == 0) ? 4095
						: 12 * $urandom_range(0, 341);
				endcase
				add_cmd(kind, $urandom_range(0, 31), $urandom_range(0, 15),
					$urandom_range(0, 65535), amt, gap);
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted != total_cmds || due_dates.size() != 0)
			@(posedge clk);
		// late or stray results would still be caught here
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d items: %0d loads (%0d rejected), %0d day, %0d month, %0d year adds",
			accepted, kind_count[cda_pkg::REQ_LOAD], bad_loads, kind_count[cda_pkg::REQ_DAYS],
			kind_count[cda_pkg::REQ_MONTHS], kind_count[cda_pkg::REQ_YEARS]);
		$display("%0d results compared, %0d saturated the year, %0d mismatches",
			results_seen, saturations, mismatches);
		if (mismatches == 0 && due_dates.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[sim.f]
src/cda_pkg.sv
src/cda_divider.sv
src/calendar_date_adder_unit.sv
sim/testbench.sv
